### design/rapg_pkg.sv
// ----------------------------------------------------------------------------
// rapg_pkg: shared constants and helpers for the range arc point generator
// Holds the sine polynomial coefficients, widths and the saturating helper.
// ----------------------------------------------------------------------------
package rapg_pkg;

    localparam int ANG_W   = 16;
    localparam int RANGE_W = 16;
    localparam int COORD_W = 24;
    localparam int TRIG_W  = 18;
    localparam int MUL_W   = 32;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_POINTS_PER_SIDE = 2'd0;
    localparam logic [1:0] REG_HEIGHT_MODE     = 2'd1;

    localparam logic [31:0] COEF_C1 = 32'd1686629713;
    localparam logic [31:0] COEF_C3 = 32'd693598666;
    localparam logic [31:0] COEF_C5 = 32'd85569306;
    localparam logic [31:0] COEF_C7 = 32'd5026994;
    localparam logic [31:0] COEF_C9 = 32'd172271;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Coefficient used by the k-th Horner step (x^7 term first).
    function automatic logic [31:0] poly_coef(input logic [1:0] k);
        logic [31:0] c;
        case (k)
            2'd0:    c = COEF_C7;
            2'd1:    c = COEF_C5;
            2'd2:    c = COEF_C3;
            default: c = COEF_C1;
        endcase
        return c;
    endfunction

    // Offset plus product, clamped to the 24-bit coordinate range.
    function automatic coord_t add_sat(input coord_t base, input trig_t delta);
        logic signed [COORD_W:0] sum;
        coord_t res;
        sum = {base[COORD_W-1], base} + {{(COORD_W+1-TRIG_W){delta[TRIG_W-1]}}, delta};
        if (sum[COORD_W] != sum[COORD_W-1])
            res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            res = sum[COORD_W-1:0];
        return res;
    endfunction

endpackage

### design/rapg_mul.sv
// ----------------------------------------------------------------------------
// rapg_mul: bit-serial shift-and-add multiplier
// Multiplies two 32-bit unsigned operands, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rapg_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rapg_pkg::MUL_W-1:0]    op_a,
    input  logic [rapg_pkg::MUL_W-1:0]    op_b,
    output logic                          done,
    output logic [2*rapg_pkg::MUL_W-1:0]  prod
);
    import rapg_pkg::*;

    logic [MUL_W-1:0]   ma_reg;
    logic [MUL_W-1:0]   mb_reg;
    logic [2*MUL_W-1:0] acc_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_W:0]     sum;

    assign sum  = {1'b0, acc_reg[2*MUL_W-1:MUL_W]} + (mb_reg[0] ? {1'b0, ma_reg} : '0);
    assign done = done_reg;
    assign prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= op_a;
            mb_reg  <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[MUL_W-1:1]};
            mb_reg  <= {1'b0, mb_reg[MUL_W-1:1]};
        end
    end

endmodule

### design/rapg_div.sv
// ----------------------------------------------------------------------------
// rapg_div: bit-serial restoring divider for the angular step
// Divides the 16-bit field of view by a small divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rapg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rapg_pkg::ANG_W-1:0]  dividend,
    input  logic [2:0]                  divisor,
    output logic                        done,
    output logic [rapg_pkg::ANG_W-1:0]  quotient
);
    import rapg_pkg::*;

    logic [ANG_W-1:0] q_reg;
    logic [2:0]       rem_reg;
    logic [2:0]       d_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [3:0]       trial;
    logic             fits;

    assign trial    = {rem_reg, q_reg[ANG_W-1]};
    assign fits     = trial >= {1'b0, d_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 3'(trial - {1'b0, d_reg}) : trial[2:0];
            q_reg   <= {q_reg[ANG_W-2:0], fits};
        end
    end

endmodule

### design/rapg_trig.sv
// ----------------------------------------------------------------------------
// rapg_trig: scaled sine sequencer
// Computes round(r * sin(angle)) with a Horner polynomial on the serial multiplier.
// ----------------------------------------------------------------------------
module rapg_trig (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rapg_pkg::ANG_W-1:0]    angle,
    input  logic [rapg_pkg::RANGE_W-1:0]  range_val,
    output logic                          done,
    output rapg_pkg::trig_t               result
);
    import rapg_pkg::*;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_X2   = 3'd1;
    localparam logic [2:0] T_POLY = 3'd2;
    localparam logic [2:0] T_S    = 3'd3;
    localparam logic [2:0] T_RM   = 3'd4;

    logic [2:0]         state_reg;
    logic [1:0]         k_reg;
    logic               neg_reg;
    logic               done_reg;
    logic [30:0]        x_reg;
    logic [30:0]        x2_reg;
    logic [RANGE_W-1:0] r_reg;
    trig_t              res_reg;
    logic               mul_start_reg;
    logic [MUL_W-1:0]   mul_a_reg;
    logic [MUL_W-1:0]   mul_b_reg;
    logic               mul_done;
    logic [2*MUL_W-1:0] mul_prod;

    logic [14:0]        folded;
    logic [31:0]        p_new;
    logic [31:0]        s_round;
    logic [16:0]        mag;
    logic [33:0]        m_round;
    logic [16:0]        m_val;

    rapg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .op_a  (mul_a_reg),
        .op_b  (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        folded  = angle[14] ? 15'(15'h4000 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        p_new   = poly_coef(k_reg) - mul_prod[61:30];
        s_round = mul_prod[61:30] + 32'd8192;
        mag     = (s_round[31:14] > 18'd65536) ? 17'h10000 : s_round[30:14];
        m_round = mul_prod[33:0] + 34'd32768;
        m_val   = m_round[32:16];
    end

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= T_X2;
                    end
                end
                T_X2:
                begin
                    if (mul_done)
                    begin
                        k_reg         <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= T_POLY;
                    end
                end
                T_POLY:
                begin
                    if (mul_done)
                    begin
                        k_reg         <= k_reg + 2'd1;
                        mul_start_reg <= 1'b1;
                        if (k_reg == 2'd3)
                            state_reg <= T_S;
                    end
                end
                T_S:
                begin
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= T_RM;
                    end
                end
                T_RM:
                begin
                    if (mul_done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    x_reg     <= {folded, 16'b0};
                    neg_reg   <= angle[15];
                    r_reg     <= range_val;
                    mul_a_reg <= {1'b0, folded, 16'b0};
                    mul_b_reg <= {1'b0, folded, 16'b0};
                end
            end
            T_X2:
            begin
                if (mul_done)
                begin
                    x2_reg    <= mul_prod[60:30];
                    mul_a_reg <= COEF_C9;
                    mul_b_reg <= {1'b0, mul_prod[60:30]};
                end
            end
            T_POLY:
            begin
                if (mul_done)
                begin
                    mul_a_reg <= p_new;
                    mul_b_reg <= (k_reg == 2'd3) ? {1'b0, x_reg} : {1'b0, x2_reg};
                end
            end
            T_S:
            begin
                if (mul_done)
                begin
                    mul_a_reg <= {16'b0, r_reg};
                    mul_b_reg <= {15'b0, mag};
                end
            end
            T_RM:
            begin
                if (mul_done)
                    res_reg <= neg_reg ? -$signed({1'b0, m_val}) : $signed({1'b0, m_val});
            end
            default:
            begin
            end
        endcase
    end

endmodule

### design/range_arc_point_generator_top.sv
// ----------------------------------------------------------------------------
// range_arc_point_generator_top: fan of arc points from one range reading
// Sequences the step divider and the serial sine unit over the point fan.
// ----------------------------------------------------------------------------
// Usage: one range reading is offered on the input channel (in_valid with the
// payload ports); it is taken as a beat at an edge where in_valid is high and
// in_stall is low. in_stall stays high from that edge until the last point of
// the fan has been loaded into the output register, so one reading is worked
// on at a time. Points leave on the output channel as beats, the final one
// with last_point set. The flat fan has 2N+1 points; the height fan has
// (2N+1)*2N points.
// The step divider runs first, then the N-fold negative offset, and each sine
// evaluation runs seven serial multiplications. Flat mode needs two
// evaluations per point, height mode two per column plus one per point, so
// a full height fan with N = 3 takes 56 evaluations. When the receiver
// stalls, the finished point waits in the output register and the sequencer
// holds in S_EMIT until it is taken. Reset clears the control state, sets N
// to 2 and selects flat mode; configuration writes apply to the next reading
// and are to be made by the user only while the block is idle, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module range_arc_point_generator_top #(
    parameter int MAX_POINTS_PER_SIDE = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [1:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rapg_pkg::RANGE_W-1:0]  range_mm,
    input  logic [rapg_pkg::ANG_W-1:0]    view_angle,
    input  logic [rapg_pkg::ANG_W-1:0]    heading,
    input  rapg_pkg::coord_t              offset_x,
    input  rapg_pkg::coord_t              offset_y,
    input  rapg_pkg::coord_t              offset_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rapg_pkg::coord_t              point_x,
    output rapg_pkg::coord_t              point_y,
    output rapg_pkg::coord_t              point_z,
    output logic                          last_point
);
    import rapg_pkg::*;

    localparam logic [1:0] MAX_N      = 2'(MAX_POINTS_PER_SIDE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_NEG  = 3'd2;
    localparam logic [2:0] S_COS  = 3'd3;
    localparam logic [2:0] S_SIN  = 3'd4;
    localparam logic [2:0] S_ZS   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [1:0]         npts_reg;
    logic               height_reg;
    logic [2:0]         state_reg;
    logic [1:0]         n_reg;
    logic               hmode_reg;
    logic [RANGE_W-1:0] r_reg;
    logic [ANG_W-1:0]   fov_reg;
    logic [ANG_W-1:0]   head_reg;
    coord_t             ox_reg;
    coord_t             oy_reg;
    coord_t             oz_reg;
    logic [ANG_W-1:0]   step_reg;
    logic [ANG_W-1:0]   neg_reg;
    logic [ANG_W-1:0]   ang_reg;
    logic [ANG_W-1:0]   va_reg;
    logic [1:0]         k_reg;
    logic [2:0]         i_reg;
    logic [2:0]         j_reg;
    coord_t             px_reg;
    coord_t             py_reg;
    coord_t             pz_reg;
    logic               trig_start_reg;
    logic [ANG_W-1:0]   trig_ang_reg;
    logic               div_start_reg;
    logic               out_valid_reg;
    coord_t             ox_out_reg;
    coord_t             oy_out_reg;
    coord_t             oz_out_reg;
    logic               last_out_reg;

    logic [1:0]         n_eff;
    logic [2:0]         two_n;
    logic               div_done;
    logic [ANG_W-1:0]   div_q;
    logic               trig_done;
    trig_t              trig_res;
    logic               out_free;
    logic               last_col;
    logic               last_row;

    // Out-of-range side counts are pulled into one .. MAX_POINTS_PER_SIDE.
    always_comb
    begin
        if (npts_reg == 2'd0)
            n_eff = 2'd1;
        else if (npts_reg > MAX_N)
            n_eff = MAX_N;
        else
            n_eff = npts_reg;
    end

    assign two_n    = {n_reg, 1'b0};
    assign out_free = !out_valid_reg || !out_stall;
    assign last_col = (i_reg == two_n);
    assign last_row = !hmode_reg || (j_reg == 3'(two_n - 3'd1));
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid  = out_valid_reg;
    assign point_x    = ox_out_reg;
    assign point_y    = oy_out_reg;
    assign point_z    = oz_out_reg;
    assign last_point = last_out_reg;

    rapg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (fov_reg),
        .divisor  ({n_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    rapg_trig u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (trig_start_reg),
        .angle     (trig_ang_reg),
        .range_val (r_reg),
        .done      (trig_done),
        .result    (trig_res)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npts_reg   <= 2'd2;
            height_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POINTS_PER_SIDE: npts_reg   <= cfg_data;
                REG_HEIGHT_MODE:     height_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Control sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            trig_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            trig_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_NEG;
                    end
                end
                S_NEG:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == n_reg)
                    begin
                        i_reg          <= '0;
                        trig_start_reg <= 1'b1;
                        state_reg      <= S_COS;
                    end
                end
                S_COS:
                begin
                    if (trig_done)
                    begin
                        trig_start_reg <= 1'b1;
                        state_reg      <= S_SIN;
                    end
                end
                S_SIN:
                begin
                    if (trig_done)
                    begin
                        j_reg <= '0;
                        if (hmode_reg)
                        begin
                            trig_start_reg <= 1'b1;
                            state_reg      <= S_ZS;
                        end
                        else
                            state_reg <= S_EMIT;
                    end
                end
                S_ZS:
                begin
                    if (trig_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!last_row)
                        begin
                            j_reg          <= j_reg + 3'd1;
                            trig_start_reg <= 1'b1;
                            state_reg      <= S_ZS;
                        end
                        else if (!last_col)
                        begin
                            i_reg          <= i_reg + 3'd1;
                            trig_start_reg <= 1'b1;
                            state_reg      <= S_COS;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; the sine unit angle is registered together with its start strobe.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_reg     <= n_eff;
                    hmode_reg <= height_reg;
                    r_reg     <= range_mm;
                    fov_reg   <= view_angle;
                    head_reg  <= heading;
                    ox_reg    <= offset_x;
                    oy_reg    <= offset_y;
                    oz_reg    <= offset_z;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    step_reg <= div_q;
                    neg_reg  <= '0;
                end
            end
            S_NEG:
            begin
                if (k_reg == n_reg)
                begin
                    ang_reg      <= head_reg + neg_reg;
                    trig_ang_reg <= head_reg + neg_reg + QUARTER_TURN;
                end
                else
                    neg_reg <= neg_reg - step_reg;
            end
            S_COS:
            begin
                if (trig_done)
                begin
                    px_reg       <= add_sat(ox_reg, trig_res);
                    trig_ang_reg <= ang_reg;
                end
            end
            S_SIN:
            begin
                if (trig_done)
                begin
                    py_reg       <= add_sat(oy_reg, trig_res);
                    pz_reg       <= oz_reg;
                    va_reg       <= neg_reg;
                    trig_ang_reg <= neg_reg;
                end
            end
            S_ZS:
            begin
                if (trig_done)
                    pz_reg <= add_sat(oz_reg, trig_res);
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ox_out_reg   <= px_reg;
                    oy_out_reg   <= py_reg;
                    oz_out_reg   <= pz_reg;
                    last_out_reg <= last_col && last_row;
                    if (!last_row)
                    begin
                        va_reg       <= va_reg + step_reg;
                        trig_ang_reg <= va_reg + step_reg;
                    end
                    else
                    begin
                        ang_reg      <= ang_reg + step_reg;
                        trig_ang_reg <= ang_reg + step_reg + QUARTER_TURN;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
